// ===== design/vrrt_pkg.sv =====
// shared types, widths, event and register codes for the view refresh request tracker
// no dependencies; imported by every module of the block
package vrrt_pkg;

    localparam int VIEW_COUNT = 8;
    localparam int VIEW_W     = $clog2(VIEW_COUNT);
    localparam int CNT_W      = $clog2(VIEW_COUNT + 1);
    localparam int SEQ_BITS   = 32;
    localparam int ID_W       = 32;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 9;
    localparam int LIMIT_GRP  = 4;
    localparam int TIMEOUT_W  = 16;
    localparam int ENABLE_W   = 8;
    localparam int CFG_W      = LIMIT_GRP * LIMIT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int EVENT_W    = 4;
    localparam int MODE_W     = 2;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_TICK     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_INVALID  = 4'd1;
    localparam logic [EVENT_W-1:0] EV_DISABLED = 4'd2;
    localparam logic [EVENT_W-1:0] EV_UPTODATE = 4'd3;
    localparam logic [EVENT_W-1:0] EV_BUSY     = 4'd4;
    localparam logic [EVENT_W-1:0] EV_ISSUED   = 4'd5;
    localparam logic [EVENT_W-1:0] EV_REISSUE  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_STALE    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_ACCEPTED = 4'd8;
    localparam logic [EVENT_W-1:0] EV_FOLLOWUP = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd3;

    localparam logic [ENABLE_W-1:0]  ENABLE_RESET     = 8'd126;
    localparam logic [CFG_W-1:0]     LIMIT_LOW_RESET  = 36'd201342976;
    localparam logic [CFG_W-1:0]     LIMIT_HIGH_RESET = 36'd4194305;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 16'd1500;

    typedef logic [VIEW_COUNT-1:0]                view_vec_t;
    typedef logic [VIEW_COUNT-1:0][SEQ_BITS-1:0]  seq_arr_t;
    typedef logic [VIEW_COUNT-1:0][ID_W-1:0]      id_arr_t;
    typedef logic [VIEW_COUNT-1:0][TIME_W-1:0]    time_arr_t;
    typedef logic [LIMIT_GRP-1:0][LIMIT_W-1:0]    limit_grp_t;

    typedef struct packed {
        logic [ENABLE_W-1:0]  enable_mask;
        limit_grp_t           limit_low;
        limit_grp_t           limit_high;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                change_name_ok;
        logic [VIEW_W-1:0]   change_view;
        logic [SEQ_BITS-1:0] change_seq;
        logic                snap_name_ok;
        logic [VIEW_W-1:0]   snap_view;
        logic [SEQ_BITS-1:0] snap_seq;
        logic [ID_W-1:0]     request_id;
        logic                changed;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic                req_valid;
        logic [VIEW_W-1:0]   req_view;
        logic [SEQ_BITS-1:0] req_since_seq;
        logic [LIMIT_W-1:0]  req_limit;
        logic [ID_W-1:0]     req_id;
        logic                changed_echo;
        logic [CNT_W-1:0]    pending_views;
        logic [CNT_W-1:0]    inflight_views;
    } result_t;

    typedef struct packed {
        view_vec_t         pending;
        seq_arr_t          pseq;
        seq_arr_t          applied;
        view_vec_t         busy;
        id_arr_t           rid;
        time_arr_t         start;
        logic [ID_W-1:0]   next_id;
        logic [TIME_W-1:0] time_now;
    } view_state_t;

    typedef struct packed {
        logic                wr;
        logic [VIEW_W-1:0]   view;
        logic                pending;
        logic [SEQ_BITS-1:0] pseq;
        logic [SEQ_BITS-1:0] applied;
        logic                busy;
        logic [ID_W-1:0]     rid;
        logic [TIME_W-1:0]   start;
        logic                id_adv;
        logic                time_inc;
    } view_upd_t;

    function automatic logic [CNT_W-1:0] popcount(input view_vec_t vec);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < VIEW_COUNT; i++)
        begin
            n = n + CNT_W'(vec[i]);
        end
        return n;
    endfunction

endpackage

// ===== design/view_refresh_request_tracker_core.sv =====
// Refresh request tracker for up to eight views, at most one request in flight per view.
// Each word enters an input register; the decision logic then reads the selected
// view's registers, updates them and loads the result register once that register is free,
// so each result is registered in turn by the input register and the result register. One word
// is accepted every cycle while the output side takes results; throughput is set by the
// read-modify-write of the per-view state registers. Configuration is written
// through a plain write port.
// depends on vrrt_pkg, vrrt_cfg, vrrt_views, vrrt_step
module view_refresh_request_tracker_core
    import vrrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic                 change_name_ok,
    input  logic [VIEW_W-1:0]    change_view,
    input  logic [SEQ_BITS-1:0]  change_seq,
    input  logic                 snap_name_ok,
    input  logic [VIEW_W-1:0]    snap_view,
    input  logic [SEQ_BITS-1:0]  snap_seq,
    input  logic [ID_W-1:0]      request_id,
    input  logic                 changed,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVENT_W-1:0]   event_res,
    output logic                 req_valid,
    output logic [VIEW_W-1:0]    req_view,
    output logic [SEQ_BITS-1:0]  req_since_seq,
    output logic [LIMIT_W-1:0]   req_limit,
    output logic [ID_W-1:0]      req_id,
    output logic                 changed_echo,
    output logic [CNT_W-1:0]     pending_views,
    output logic [CNT_W-1:0]     inflight_views
);

    cfg_t        cfg;
    view_state_t st;
    view_upd_t   upd;
    result_t     res;

    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;

    logic    advance;
    logic    fire;

    // the result register frees up when empty or when its word is taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg.mode           <= mode;
            in_item_reg.change_name_ok <= change_name_ok;
            in_item_reg.change_view    <= change_view;
            in_item_reg.change_seq     <= change_seq;
            in_item_reg.snap_name_ok   <= snap_name_ok;
            in_item_reg.snap_view      <= snap_view;
            in_item_reg.snap_seq       <= snap_seq;
            in_item_reg.request_id     <= request_id;
            in_item_reg.changed        <= changed;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    vrrt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vrrt_views u_views
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .upd   (upd),
        .st    (st)
    );

    vrrt_step u_step
    (
        .item (in_item_reg),
        .st   (st),
        .cfg  (cfg),
        .upd  (upd),
        .res  (res)
    );

    assign out_valid      = out_valid_reg;
    assign event_res      = res_reg.event_res;
    assign req_valid      = res_reg.req_valid;
    assign req_view       = res_reg.req_view;
    assign req_since_seq  = res_reg.req_since_seq;
    assign req_limit      = res_reg.req_limit;
    assign req_id         = res_reg.req_id;
    assign changed_echo   = res_reg.changed_echo;
    assign pending_views  = res_reg.pending_views;
    assign inflight_views = res_reg.inflight_views;

    a_req_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (req_valid == (event_res == EV_ISSUED || event_res == EV_REISSUE
                                     || event_res == EV_FOLLOWUP)))
        else $error("request flag disagrees with event code");

    a_idle_request_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !req_valid |-> (req_id == '0 && req_since_seq == '0
                                     && req_limit == '0 && req_view == '0))
        else $error("request fields set without a request");

    a_echo_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed_echo |-> (event_res == EV_ACCEPTED || event_res == EV_FOLLOWUP))
        else $error("changed echo outside an accepted response");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_views <= CNT_W'(VIEW_COUNT)
                       && inflight_views <= CNT_W'(VIEW_COUNT)))
        else $error("view count beyond the number of views");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held input word lost while the result register is full");

endmodule

// ===== design/vrrt_cfg.sv =====
// configuration registers of the tracker: enable mask, item limits, timeout
// depends on vrrt_pkg
module vrrt_cfg
    import vrrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask   <= ENABLE_RESET;
            cfg_reg.limit_low     <= LIMIT_LOW_RESET;
            cfg_reg.limit_high    <= LIMIT_HIGH_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:     cfg_reg.enable_mask   <= cfg_wdata[ENABLE_W-1:0];
                CFG_LIMIT_LOW:  cfg_reg.limit_low     <= cfg_wdata;
                CFG_LIMIT_HIGH: cfg_reg.limit_high    <= cfg_wdata;
                CFG_TIMEOUT:    cfg_reg.timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/vrrt_views.sv =====
// per-view state registers, request id counter and tick clock
// depends on vrrt_pkg; written from the update produced by vrrt_step
module vrrt_views
    import vrrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  view_upd_t   upd,
    output view_state_t st
);

    view_vec_t         pending_reg;
    seq_arr_t          pseq_reg;
    seq_arr_t          applied_reg;
    view_vec_t         busy_reg;
    id_arr_t           rid_reg;
    time_arr_t         start_reg;
    logic [ID_W-1:0]   next_id_reg;
    logic [TIME_W-1:0] time_now_reg;
    logic [ID_W-1:0]   next_id_next;

    // id zero is never handed out
    assign next_id_next = (next_id_reg == '1) ? ID_W'(1) : next_id_reg + ID_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            pseq_reg     <= '0;
            applied_reg  <= '0;
            busy_reg     <= '0;
            rid_reg      <= '0;
            start_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            time_now_reg <= '0;
        end
        else if (fire)
        begin
            if (upd.wr)
            begin
                pending_reg[upd.view] <= upd.pending;
                pseq_reg[upd.view]    <= upd.pseq;
                applied_reg[upd.view] <= upd.applied;
                busy_reg[upd.view]    <= upd.busy;
                rid_reg[upd.view]     <= upd.rid;
                start_reg[upd.view]   <= upd.start;
            end
            if (upd.id_adv)
            begin
                next_id_reg <= next_id_next;
            end
            if (upd.time_inc)
            begin
                time_now_reg <= time_now_reg + TIME_W'(1);
            end
        end
    end

    assign st.pending  = pending_reg;
    assign st.pseq     = pseq_reg;
    assign st.applied  = applied_reg;
    assign st.busy     = busy_reg;
    assign st.rid      = rid_reg;
    assign st.start    = start_reg;
    assign st.next_id  = next_id_reg;
    assign st.time_now = time_now_reg;

endmodule

// ===== design/vrrt_step.sv =====
// single-pass decision logic: one word against the selected view's state
// depends on vrrt_pkg; purely combinational
module vrrt_step
    import vrrt_pkg::*;
(
    input  item_t       item,
    input  view_state_t st,
    input  cfg_t        cfg,
    output view_upd_t   upd,
    output result_t     res
);

    logic                change_ok;
    logic                snap_ok;
    logic                sel_ok;
    logic                en;
    logic                busy_v;
    logic                expired;
    logic [VIEW_W-1:0]   v;
    logic [SEQ_BITS-1:0] sel_seq;
    logic [SEQ_BITS-1:0] applied_v;
    logic [SEQ_BITS-1:0] pseq_v;
    logic [SEQ_BITS-1:0] pseq_max;
    logic [SEQ_BITS-1:0] applied_sel;
    logic [SEQ_BITS-1:0] applied_new;
    logic [TIME_W-1:0]   age;
    logic [LIMIT_W-1:0]  limit_v;
    view_vec_t           pend_next;
    view_vec_t           busy_next;

    assign change_ok = item.change_name_ok && (item.change_seq != '0);
    assign snap_ok   = item.snap_name_ok && (item.snap_seq != '0);

    // a response falls back on the snapshot's own view record
    always_comb
    begin
        if (item.mode == MODE_RESP && !change_ok)
        begin
            v       = item.snap_view;
            sel_seq = item.snap_seq;
            sel_ok  = snap_ok;
        end
        else
        begin
            v       = item.change_view;
            sel_seq = item.change_seq;
            sel_ok  = change_ok;
        end
    end

    assign en        = cfg.enable_mask[v];
    assign busy_v    = st.busy[v];
    assign applied_v = st.applied[v];
    assign pseq_v    = st.pseq[v];
    assign age       = st.time_now - st.start[v];
    assign expired   = age >= {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_ticks};
    assign limit_v   = v[VIEW_W-1] ? cfg.limit_high[v[VIEW_W-2:0]]
                                   : cfg.limit_low[v[VIEW_W-2:0]];

    assign pseq_max    = (item.change_seq > pseq_v) ? item.change_seq : pseq_v;
    assign applied_sel = (sel_seq > applied_v) ? sel_seq : applied_v;
    assign applied_new = (item.changed && item.snap_seq > applied_sel) ? item.snap_seq
                                                                       : applied_sel;

    always_comb
    begin
        upd.wr       = 1'b0;
        upd.view     = v;
        upd.pending  = st.pending[v];
        upd.pseq     = pseq_v;
        upd.applied  = applied_v;
        upd.busy     = busy_v;
        upd.rid      = st.rid[v];
        upd.start    = st.start[v];
        upd.id_adv   = 1'b0;
        upd.time_inc = 1'b0;
        res          = '0;
        res.event_res = EV_TICK;

        case (item.mode)
            MODE_CHANGE:
            begin
                if (!change_ok)
                begin
                    res.event_res = EV_INVALID;
                end
                else if (!en)
                begin
                    res.event_res = EV_DISABLED;
                end
                else if (item.change_seq <= applied_v && !busy_v)
                begin
                    res.event_res = EV_UPTODATE;
                end
                else
                begin
                    upd.wr      = 1'b1;
                    upd.pending = 1'b1;
                    upd.pseq    = pseq_max;
                    if (busy_v && !expired)
                    begin
                        res.event_res = EV_BUSY;
                    end
                    else
                    begin
                        // a stale in-flight request is dropped and replaced
                        upd.busy          = 1'b1;
                        upd.rid           = st.next_id;
                        upd.start         = st.time_now;
                        upd.id_adv        = 1'b1;
                        res.event_res     = busy_v ? EV_REISSUE : EV_ISSUED;
                        res.req_valid     = 1'b1;
                        res.req_view      = v;
                        res.req_since_seq = applied_v;
                        res.req_limit     = limit_v;
                        res.req_id        = st.next_id;
                    end
                end
            end
            MODE_RESP:
            begin
                if (!sel_ok)
                begin
                    res.event_res = EV_INVALID;
                end
                else if (!busy_v || st.rid[v] != item.request_id)
                begin
                    res.event_res = EV_STALE;
                end
                else
                begin
                    upd.wr           = 1'b1;
                    upd.busy         = 1'b0;
                    upd.rid          = '0;
                    upd.start        = '0;
                    upd.applied      = applied_new;
                    res.changed_echo = item.changed;
                    res.event_res    = EV_ACCEPTED;
                    if (pseq_v > applied_new)
                    begin
                        // newer changes arrived meanwhile; a disabled view stays pending
                        if (en)
                        begin
                            upd.busy          = 1'b1;
                            upd.rid           = st.next_id;
                            upd.start         = st.time_now;
                            upd.id_adv        = 1'b1;
                            res.event_res     = EV_FOLLOWUP;
                            res.req_valid     = 1'b1;
                            res.req_view      = v;
                            res.req_since_seq = applied_new;
                            res.req_limit     = limit_v;
                            res.req_id        = st.next_id;
                        end
                    end
                    else
                    begin
                        upd.pending = 1'b0;
                        upd.pseq    = '0;
                    end
                end
            end
            MODE_TICK:
            begin
                upd.time_inc = 1'b1;
            end
            default:
            begin
                res.event_res = EV_TICK;
            end
        endcase

        pend_next = st.pending;
        busy_next = st.busy;
        if (upd.wr)
        begin
            pend_next[v] = upd.pending;
            busy_next[v] = upd.busy;
        end
        res.pending_views  = popcount(pend_next);
        res.inflight_views = popcount(busy_next);
    end

endmodule
